/* hdl/msc_pkg.sv */
// ----------------------------------------------------------------------------
// msc_pkg: shared types for the minimum square sum count block
// Command and status bundles between the controller and the datapath,
// and the width of one table entry.
// ----------------------------------------------------------------------------
package msc_pkg;

  // Width of one table entry and of the result count
  localparam int unsigned CountW = 3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // latch a new target and restart the fill
    logic step_i;       // advance to the next table index
    logic mark_square;  // index is a perfect square: write 1, move the root on
    logic start_inner;  // begin the scan over j for the current index
    logic issue;        // issue one table read and advance j
    logic write_min;    // write the folded minimum for the current index
    logic out_load;     // capture the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_range;    // target beyond the table
    logic i_done;       // current index reached the target
    logic is_square;    // current index equals the next square
    logic j_last;       // the read being issued is for j equal to the root
  } status_t;

endpackage

/* hdl/msc_ram.sv */
// ----------------------------------------------------------------------------
// msc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module msc_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/msc_datapath.sv */
// ----------------------------------------------------------------------------
// msc_datapath: counters, table and minimum fold
// Walks index i up to the target, tracks the integer root and the next
// square incrementally, scans i - j*j through the table and folds the
// minimum count, one read a cycle.
// ----------------------------------------------------------------------------
module msc_datapath #(
  parameter int unsigned MAX_TARGET = 16383
) (
  input  logic                   clk,
  input  logic                   rst,
  input  msc_pkg::cmd_t          cmd,
  output msc_pkg::status_t       status,
  input  logic [13:0]            target,
  output logic [msc_pkg::CountW-1:0] result
);
  import msc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_TARGET + 1);

  logic [AW-1:0]     n;
  logic [AW-1:0]     i;
  logic [AW-1:0]     root;
  logic [AW+1:0]     sq_next;
  logic [AW-1:0]     j;
  logic [AW-1:0]     jsq;
  logic [CountW-1:0] best;
  logic [CountW-1:0] last;
  logic              out_range;
  logic              rd_pend;

  logic              we;
  logic [CountW-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CountW-1:0] rdata;
  logic [CountW-1:0] cand;
  logic [AW+1:0]     jsq_step;

  // Status toward the controller
  assign status.out_range = out_range;
  assign status.i_done    = (i == n);
  assign status.is_square = ({2'b00, i} == sq_next);
  assign status.j_last    = (j == root);

  // Table access
  assign raddr    = i - jsq;
  assign we       = cmd.mark_square | cmd.write_min;
  assign wdata    = cmd.mark_square ? CountW'(1) : best;
  assign cand     = rdata + CountW'(1);
  assign jsq_step = {2'b00, jsq} + {1'b0, j, 1'b0} + (AW+2)'(1);

  msc_ram #(
    .WIDTH(CountW),
    .DEPTH(MAX_TARGET + 1)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(i),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Track a read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.issue;
    end
  end

  // Counters and fold
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_range <= (32'(target) > 32'(MAX_TARGET));
      n         <= AW'(target);
      i         <= '0;
      root      <= '0;
      sq_next   <= (AW+2)'(1);
      last      <= '0;
    end
    if (cmd.step_i) begin
      i <= i + AW'(1);
    end
    if (cmd.mark_square) begin
      root    <= root + AW'(1);
      sq_next <= sq_next + {1'b0, root, 1'b0} + (AW+2)'(3);
      last    <= CountW'(1);
    end
    if (cmd.start_inner) begin
      j    <= AW'(1);
      jsq  <= AW'(1);
      best <= '1;
    end
    if (cmd.issue) begin
      j   <= j + AW'(1);
      jsq <= jsq_step[AW-1:0];
    end
    if (rd_pend && cand < best) begin
      best <= cand;
    end
    if (cmd.write_min) begin
      last <= best;
    end
    // Out-of-range targets report zero
    if (cmd.out_load) begin
      result <= out_range ? '0 : last;
    end
  end

endmodule

/* hdl/msc_ctrl.sv */
// ----------------------------------------------------------------------------
// msc_ctrl: sequencer for the table fill
// Accepts a target, steps the datapath through every index, scans the
// squares below each non-square index, and hands the result to the
// output register.
// ----------------------------------------------------------------------------
module msc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output msc_pkg::cmd_t    cmd,
  input  msc_pkg::status_t status
);
  import msc_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_STEP     = 3'd1;
  localparam logic [2:0] S_CLASSIFY = 3'd2;
  localparam logic [2:0] S_INNER    = 3'd3;
  localparam logic [2:0] S_DRAIN    = 3'd4;
  localparam logic [2:0] S_WRITE    = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (status.out_range || status.i_done) begin
          state_next = S_DONE;
        end else begin
          cmd.step_i = 1'b1;
          state_next = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (status.is_square) begin
          cmd.mark_square = 1'b1;
          state_next      = S_STEP;
        end else begin
          cmd.start_inner = 1'b1;
          state_next      = S_INNER;
        end
      end
      S_INNER: begin
        cmd.issue = 1'b1;
        if (status.j_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_min = 1'b1;
        state_next    = S_STEP;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/min_square_sum_count_top.sv */
// Throughput: one target at a time; the single table read port sets the rate.
// A finished result waits in the output register while the next target is taken.
// Reset: synchronous, active high; clears the sequencer, output valid and the read-pending flag.
// The table needs no clearing: each target rewrites entries 1..n before reading.
// ----------------------------------------------------------------------------
// min_square_sum_count_top: fewest perfect squares summing to a target
// Stream in a target, stream out the minimum square count.
// ----------------------------------------------------------------------------
module min_square_sum_count_top #(
  parameter int unsigned MAX_TARGET = 16383
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] target
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [2:0] square_count
);
  import msc_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [CountW-1:0] result;

  msc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  msc_datapath #(
    .MAX_TARGET(MAX_TARGET)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .status(status),
    .target(s_tdata[13:0]),
    .result(result)
  );

  // Pad the count to a whole byte
  assign m_tdata = {(8 - CountW)'(0), result};

endmodule
